// ----- design/assert_macros.svh -----
// Assertion macros shared by the transposition cipher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ctc_pkg.sv -----
// Types, constants and helpers for the columnar transposition cipher core.
`timescale 1ns / 1ps
`default_nettype none

package ctc_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h58;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    // Depth of the request queue between front and back.
    localparam int Q_DEPTH = 2;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TOO_LONG = 2'd1,
        STATUS_NONE     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_NUM_COLS  = 2'd0,
        REG_KEY_LOW   = 2'd1,
        REG_KEY_HIGH  = 2'd2,
        REG_DECRYPT   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic       is_pull;
        logic [7:0] ch;
        logic       last;
    } op_t;

    typedef struct packed {
        logic [4:0]  num_cols;
        logic [79:0] ranks;     // {key_ranks_high, key_ranks_low}
        logic        decrypt;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_DIV_P,
        S_DIV_ROWS,
        S_EMIT
    } back_state_t;

    function automatic logic [4:0] rank_of(input logic [79:0] ranks, input logic [3:0] col);
        return ranks[5*col +: 5];
    endfunction

endpackage

`default_nettype wire

// ----- design/ctc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ctc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/ctc_front.sv -----
// Request front end: accepts input requests, classifies them, queues them.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ctc_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_req_type,
    input  wire logic [7:0]    s_in_char,
    input  wire logic          s_last_char,
    output logic               q_valid,
    output ctc_pkg::op_t       q_head,
    input  wire logic          q_pop
);
    import ctc_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int NW = $clog2(Q_DEPTH + 1);

    op_t           fifo_reg [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] count_reg;
    logic          push;
    op_t           op_in;

    assign s_ready = (count_reg != NW'(Q_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_head  = fifo_reg[rd_ptr_reg];

    always_comb begin
        op_in.is_pull = (s_req_type == REQ_PULL);
        op_in.ch      = s_in_char;
        op_in.last    = s_last_char;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && q_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= op_in;
        end
    end

    `ASSERT_IMPL(a_pop_not_empty, aclk, aresetn, q_pop, count_reg != '0, "pop from empty queue")

endmodule

`default_nettype wire

// ----- design/ctc_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ctc_div #(
    parameter int W = 9
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic      [W-1:0] quotient,
    output logic      [W-1:0] remainder
);

    localparam int CNTW = $clog2(W + 1);

    logic            busy_reg, done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [W-1:0]    quo_reg, rem_reg, div_reg;
    logic [W:0]      rem_sh, diff;
    logic            ge;

    assign rem_sh    = {rem_reg, quo_reg[W-1]};
    assign diff      = rem_sh - {1'b0, div_reg};
    assign ge        = !diff[W];
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[W-2:0], ge};
            rem_reg <= ge ? diff[W-1:0] : rem_sh[W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- design/ctc_back.sv -----
// Back end: text store, column order table, grid walk and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ctc_back #(
    parameter int GRID_ROWS = 16,
    parameter int GRID_COLS = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire ctc_pkg::cfg_t cfg,
    input  wire logic          cfg_wr,
    input  wire logic          q_valid,
    input  wire ctc_pkg::op_t  q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [7:0]         m_out_char,
    output logic               m_out_last,
    output logic [1:0]         m_status
);
    import ctc_pkg::*;

    localparam int DEPTH = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = $clog2(DEPTH + GRID_COLS);
    localparam int COLW  = $clog2(GRID_COLS);
    localparam int NW    = $clog2(GRID_COLS + 1);
    localparam int RW    = $clog2(GRID_ROWS + 1);

    back_state_t state_reg, state_next;
    logic        dirty_reg, dirty_next;

    // order table: ord = columns by (rank, column); dslot = slot of the j-th valid column
    logic [COLW-1:0] ord_reg   [GRID_COLS];
    logic [COLW-1:0] dslot_reg [GRID_COLS];
    logic [COLW-1:0] col_reg;
    logic [NW-1:0]   vi_reg, v_reg;

    logic [CW-1:0]   loaded_reg, p_reg, maj_reg, min_reg;
    logic            too_long_reg, emitting_reg;
    logic [RW-1:0]   rows_reg;

    status_t         res_status_reg;
    logic            res_last_reg, res_pad_reg;
    logic            m_valid_reg;
    logic [7:0]      m_char_reg;
    logic            m_last_reg;
    status_t         m_status_reg;

    // combinational
    logic [4:0]           eff_n;
    logic [4:0]           rank_vec [GRID_COLS];
    logic [GRID_COLS-1:0] valid_vec, bef;
    logic [4:0]           cur_rank;
    logic [COLW-1:0]      build_slot;
    logic [NW-1:0]        build_v;
    logic                 build_last, build_enter, need_pdiv;
    logic [CW-1:0]        maj_lim, min_lim, idx, idx_enc, idx_dec;
    logic [COLW-1:0]      enc_c, dec_slot;
    logic                 avail, min_wrap, walk_last, pad;
    logic [CW-1:0]        base_cnt, new_cnt;
    logic                 base_tl, can_store, new_tl;
    status_t              pull_status;
    logic                 out_free, emit_fire;
    logic                 ram_we, ram_re;
    logic [7:0]           ram_rdata;
    logic                 div_start, div_done;
    logic [DW-1:0]        div_dividend, div_divisor, div_quo, div_rem;

    // column count clamps to 2..GRID_COLS
    always_comb begin
        if (cfg.num_cols < 5'd2) begin
            eff_n = 5'd2;
        end else if (cfg.num_cols > 5'(GRID_COLS)) begin
            eff_n = 5'(GRID_COLS);
        end else begin
            eff_n = cfg.num_cols;
        end
    end

    always_comb begin
        for (int q = 0; q < GRID_COLS; q++) begin
            rank_vec[q]  = rank_of(cfg.ranks, 4'(q));
            valid_vec[q] = (5'(q) < eff_n) && (rank_vec[q] != 5'd0) && (rank_vec[q] <= eff_n);
        end
    end

    // slot of the swept column: valid columns ahead of it in (rank, column) order
    assign cur_rank = rank_vec[col_reg];
    always_comb begin
        for (int q = 0; q < GRID_COLS; q++) begin
            bef[q] = valid_vec[q] && ((rank_vec[q] < cur_rank) ||
                     ((rank_vec[q] == cur_rank) && (COLW'(q) < col_reg)));
        end
    end
    assign build_slot = COLW'($countones(bef));
    assign build_v    = vi_reg + NW'(valid_vec[col_reg]);
    assign build_last = (col_reg == COLW'(GRID_COLS - 1));
    assign need_pdiv  = emitting_reg && !too_long_reg && (!cfg.decrypt || (build_v != '0));

    // grid walk: encrypt walks (rank slot, row), decrypt walks (row, column)
    assign maj_lim   = cfg.decrypt ? CW'(rows_reg) : CW'(v_reg);
    assign min_lim   = cfg.decrypt ? CW'(v_reg) : CW'(rows_reg);
    assign avail     = (v_reg != '0) && (maj_reg < maj_lim);
    assign min_wrap  = ((min_reg + 1'b1) == min_lim);
    assign walk_last = min_wrap && ((maj_reg + 1'b1) == maj_lim);

    assign enc_c    = ord_reg[maj_reg[COLW-1:0]];
    assign dec_slot = dslot_reg[min_reg[COLW-1:0]];
    assign idx_enc  = CW'(min_reg[RW-1:0]) * CW'(eff_n) + CW'(enc_c);
    assign idx_dec  = CW'(dec_slot) * CW'(rows_reg) + CW'(maj_reg[RW-1:0]);
    assign idx      = cfg.decrypt ? idx_dec : idx_enc;
    assign pad      = (idx >= loaded_reg);

    always_comb begin
        if (!emitting_reg) begin
            pull_status = STATUS_NONE;
        end else if (too_long_reg) begin
            pull_status = STATUS_TOO_LONG;
        end else if (!avail) begin
            pull_status = STATUS_NONE;
        end else begin
            pull_status = STATUS_OK;
        end
    end

    // a load while emitting starts a fresh block
    assign base_cnt  = emitting_reg ? '0 : loaded_reg;
    assign base_tl   = emitting_reg ? 1'b0 : too_long_reg;
    assign can_store = (base_cnt < CW'(DEPTH));
    assign new_cnt   = can_store ? base_cnt + 1'b1 : base_cnt;
    assign new_tl    = base_tl || !can_store;

    assign out_free  = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (dirty_reg) begin
                    state_next = S_BUILD;
                end else if (q_valid) begin
                    if (q_head.is_pull) begin
                        state_next = S_EMIT;
                    end else if (q_head.last && !new_tl) begin
                        state_next = S_DIV_ROWS;
                    end
                end
            end
            S_BUILD: begin
                if (build_last) begin
                    if (dirty_reg) begin
                        state_next = S_BUILD;
                    end else if (need_pdiv) begin
                        state_next = S_DIV_P;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DIV_P: begin
                if (div_done) state_next = S_IDLE;
            end
            S_DIV_ROWS: begin
                if (div_done) state_next = S_IDLE;
            end
            S_EMIT: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop        = 1'b0;
        build_enter  = 1'b0;
        div_start    = 1'b0;
        div_dividend = DW'(p_reg);
        div_divisor  = cfg.decrypt ? DW'(build_v) : DW'(rows_reg);
        emit_fire    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                build_enter = dirty_reg;
                q_pop       = !dirty_reg && q_valid;
                if (q_pop && !q_head.is_pull && q_head.last && !new_tl) begin
                    div_start    = 1'b1;
                    div_dividend = DW'(new_cnt) + DW'(eff_n) - DW'(1);
                    div_divisor  = DW'(eff_n);
                end
            end
            S_BUILD: begin
                build_enter = build_last && dirty_reg;
                div_start   = build_last && !dirty_reg && need_pdiv;
            end
            S_EMIT: begin
                emit_fire = out_free;
            end
            default: ;
        endcase
        dirty_next = cfg_wr || (dirty_reg && !build_enter);
    end

    assign ram_we = q_pop && !q_head.is_pull && can_store;
    assign ram_re = q_pop && q_head.is_pull;

    ctc_ram #(
        .WIDTH  (8),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_text (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (base_cnt[AW-1:0]),
        .wdata  (q_head.ch),
        .re     (ram_re),
        .raddr  (idx[AW-1:0]),
        .rdata  (ram_rdata)
    );

    ctc_div #(
        .W (DW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            dirty_reg    <= 1'b1;
            col_reg      <= '0;
            vi_reg       <= '0;
            v_reg        <= '0;
            loaded_reg   <= '0;
            too_long_reg <= 1'b0;
            emitting_reg <= 1'b0;
            rows_reg     <= '0;
            p_reg        <= '0;
            maj_reg      <= '0;
            min_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            dirty_reg <= dirty_next;

            if (build_enter) begin
                col_reg <= '0;
                vi_reg  <= '0;
            end else if (state_reg == S_BUILD) begin
                col_reg <= col_reg + 1'b1;
                vi_reg  <= build_v;
                if (build_last) v_reg <= build_v;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (q_pop && !q_head.is_pull) begin
                        loaded_reg   <= new_cnt;
                        too_long_reg <= new_tl;
                        emitting_reg <= 1'b0;
                        if (q_head.last && new_tl) begin
                            emitting_reg <= 1'b1;
                            rows_reg     <= '0;
                            p_reg        <= '0;
                            maj_reg      <= '0;
                            min_reg      <= '0;
                        end
                    end else if (q_pop && (pull_status == STATUS_OK)) begin
                        p_reg <= p_reg + 1'b1;
                        if (min_wrap) begin
                            min_reg <= '0;
                            maj_reg <= maj_reg + 1'b1;
                        end else begin
                            min_reg <= min_reg + 1'b1;
                        end
                    end
                end
                S_DIV_P: begin
                    if (div_done) begin
                        maj_reg <= div_quo[CW-1:0];
                        min_reg <= div_rem[CW-1:0];
                    end
                end
                S_DIV_ROWS: begin
                    if (div_done) begin
                        emitting_reg <= 1'b1;
                        p_reg        <= '0;
                        maj_reg      <= '0;
                        min_reg      <= '0;
                        if (div_quo > DW'(GRID_ROWS)) begin
                            too_long_reg <= 1'b1;
                            rows_reg     <= '0;
                        end else begin
                            rows_reg <= div_quo[RW-1:0];
                        end
                    end
                end
                default: ;
            endcase

            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_BUILD) && !build_enter && valid_vec[col_reg]) begin
            ord_reg[build_slot]            <= col_reg;
            dslot_reg[vi_reg[COLW-1:0]]    <= build_slot;
        end
        if (q_pop && q_head.is_pull) begin
            res_status_reg <= pull_status;
            res_last_reg   <= walk_last;
            res_pad_reg    <= pad;
        end
        if (emit_fire) begin
            m_status_reg <= res_status_reg;
            if (res_status_reg == STATUS_OK) begin
                m_char_reg <= res_pad_reg ? PAD_CHAR : ram_rdata;
                m_last_reg <= res_last_reg;
            end else begin
                m_char_reg <= 8'h00;
                m_last_reg <= 1'b0;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_char = m_char_reg;
    assign m_out_last = m_last_reg;
    assign m_status   = m_status_reg;

    `ASSERT_IMPL(a_div_done_state, aclk, aresetn, div_done, (state_reg == S_DIV_P) || (state_reg == S_DIV_ROWS), "divider finished outside a divide state")
    `ASSERT_IMPL(a_rows_range, aclk, aresetn, emitting_reg && !too_long_reg, (rows_reg != '0) && (rows_reg <= RW'(GRID_ROWS)), "row count out of range while emitting")
    `ASSERT_NEXT(a_pull_to_emit, aclk, aresetn, q_pop && q_head.is_pull, state_reg == S_EMIT, "pull request did not reach result stage")

endmodule

`default_nettype wire

// ----- design/columnar_transposition_cipher_core.sv -----
// Columnar transposition cipher core: register port, front end and back end.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   s_* channel carries requests: load (s_req_type 0) stores s_in_char, s_last_char
//   closes the text block; pull (s_req_type 1) asks for the next transposed byte.
//   m_* channel returns one result per pull: m_out_char, m_out_last, m_status
//   (0 ok, 1 text too long, 2 nothing ready). Loads give no result.
//   Registers sit on the APB port at 8*i: num_cols, key_ranks_low, key_ranks_high,
//   decrypt_mode. Write them only while no request is outstanding.
// Flow:
//   A two-entry request queue separates input from the back end, so requests keep
//   flowing while a result waits in the output register.
//   Load: written to the text RAM as it leaves the queue. Pull: order-table lookup
//   and row multiply into the text RAM address, then the registered RAM read, then
//   the result register, loaded once the output is free.
//   Last byte of a block: an extra pass through the iterative divider, with a width
//   of ceil(log2(GRID_ROWS*GRID_COLS + GRID_COLS)) bits, that sizes the row count.
//   A register write triggers a rebuild of the column order table, plus one divider
//   pass when a block is being read out.
// Reset: all control state clears and the order table is rebuilt; requests queue
//   meanwhile. The text RAM is not cleared.
// Stall: while m_ready is low the result holds and the queue fills, then s_ready drops.

module columnar_transposition_cipher_core #(
    parameter int GRID_ROWS = 16,
    parameter int GRID_COLS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [7:0]  s_in_char,
    input  wire logic        s_last_char,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_char,
    output logic             m_out_last,
    output logic [1:0]       m_status,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import ctc_pkg::*;

    logic [4:0]  num_cols_reg;
    logic [39:0] key_low_reg, key_high_reg;
    logic        decrypt_reg;
    logic        cfg_wr;
    reg_idx_t    reg_sel;
    cfg_t        cfg;
    op_t         q_head;
    logic        q_valid, q_pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[4:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cols_reg <= 5'd2;
            key_low_reg  <= '0;
            key_high_reg <= '0;
            decrypt_reg  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_NUM_COLS: num_cols_reg <= pwdata[4:0];
                REG_KEY_LOW:  key_low_reg  <= pwdata[39:0];
                REG_KEY_HIGH: key_high_reg <= pwdata[39:0];
                REG_DECRYPT:  decrypt_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_NUM_COLS: prdata = {59'd0, num_cols_reg};
            REG_KEY_LOW:  prdata = {24'd0, key_low_reg};
            REG_KEY_HIGH: prdata = {24'd0, key_high_reg};
            REG_DECRYPT:  prdata = {63'd0, decrypt_reg};
            default:      prdata = 64'd0;
        endcase
    end

    always_comb begin
        cfg.num_cols = num_cols_reg;
        cfg.ranks    = {key_high_reg, key_low_reg};
        cfg.decrypt  = decrypt_reg;
    end

    ctc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_in_char   (s_in_char),
        .s_last_char (s_last_char),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop)
    );

    ctc_back #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .cfg_wr     (cfg_wr),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_out_last (m_out_last),
        .m_status   (m_status)
    );

endmodule

`default_nettype wire
